// ===== rtl/core/multicast_group_table_macros.svh =====
// assertion helpers used by the rtl datapath module
`ifndef MULTICAST_GROUP_TABLE_MACROS_SVH
`define MULTICAST_GROUP_TABLE_MACROS_SVH

// property that holds on every clock edge outside reset
`define MGT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked also during reset
`define MGT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/mgt_pkg.sv =====
package mgt_pkg;

    localparam int unsigned MaxGroup = 255;
    localparam int unsigned NumNodes = 64;
    localparam int unsigned GidW     = 8;
    localparam int unsigned MaskW    = 64;

    typedef enum logic [2:0] {
        MODE_ASSIGN = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_LOCK   = 3'd2,
        MODE_UNLOCK = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FAIL = 2'd1;
    localparam logic [1:0] STAT_NF   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB_CHK,
        ST_REU_STEP,
        ST_REU_CHK,
        ST_ONE_RD,
        ST_ONE_DO,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;         // capture request
        logic sub_start;    // reset scan id and best
        logic sub_next;     // evaluate entry, advance id
        logic reu_start;
        logic reu_step;     // advance reuse pointer
        logic one_rd;       // read addressed entry
        logic one_do;       // decide on addressed entry
        logic wr;           // write pending entry
        logic out_set;      // result register becomes valid
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  list_zero;
        logic  sub_last;    // scan id at MaxGroup
        logic  sub_hit;     // identical group found
        logic  best_zero;
        logic  reu_done;    // pointer wrapped to start
        logic  reu_free;    // probed id not locked
        logic  out_busy;    // result not yet taken
    } t_stat;

    typedef struct packed {
        logic [2:0]       mode;
        logic [MaskW-1:0] node_mask;
        logic [6:0]       node_id;
        logic [GidW-1:0]  grp_sel;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [GidW-1:0]  result_group;
        logic [MaskW-1:0] member_mask;
        logic             group_locked;
        logic             reuse_notice;
    } t_rsp;

endpackage

// ===== rtl/core/mgt_if.sv =====
interface mgt_req_if;
    logic           valid;
    logic           ready;
    mgt_pkg::t_req  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mgt_rsp_if;
    logic           valid;
    logic           ready;
    mgt_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/mgt_ctrl.sv =====
module mgt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mgt_pkg::t_stat i_stat,
    output mgt_pkg::t_cmd  o_cmd
);
    mgt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mgt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            mgt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mgt_pkg::ST_ONE_RD;
                end
            end
            mgt_pkg::ST_ONE_RD: begin
                if (i_stat.mode == mgt_pkg::MODE_ASSIGN) begin
                    if (i_stat.list_zero) begin
                        n_state = mgt_pkg::ST_OUT;
                    end else begin
                        o_cmd.sub_start = 1'b1;
                        n_state = mgt_pkg::ST_SUB_RD;
                    end
                end else begin
                    o_cmd.one_rd = 1'b1;
                    n_state = mgt_pkg::ST_ONE_DO;
                end
            end
            mgt_pkg::ST_ONE_DO: begin
                o_cmd.one_do = 1'b1;
                n_state = mgt_pkg::ST_WRITE;
            end
            mgt_pkg::ST_SUB_RD: n_state = mgt_pkg::ST_SUB_CHK;
            mgt_pkg::ST_SUB_CHK: begin
                o_cmd.sub_next = 1'b1;
                if (i_stat.sub_hit) begin
                    n_state = mgt_pkg::ST_WRITE;
                end else if (i_stat.sub_last) begin
                    if (i_stat.best_zero) begin
                        o_cmd.reu_start = 1'b1;
                        n_state = mgt_pkg::ST_REU_STEP;
                    end else begin
                        n_state = mgt_pkg::ST_WRITE;
                    end
                end else begin
                    n_state = mgt_pkg::ST_SUB_RD;
                end
            end
            mgt_pkg::ST_REU_STEP: begin
                o_cmd.reu_step = 1'b1;
                n_state = mgt_pkg::ST_REU_CHK;
            end
            mgt_pkg::ST_REU_CHK: begin
                if (i_stat.reu_done || i_stat.reu_free) begin
                    n_state = mgt_pkg::ST_WRITE;
                end else begin
                    n_state = mgt_pkg::ST_REU_STEP;
                end
            end
            mgt_pkg::ST_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state = mgt_pkg::ST_OUT;
            end
            mgt_pkg::ST_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_set = 1'b1;
                    n_state = mgt_pkg::ST_IDLE;
                end
            end
            default: n_state = mgt_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/core/mgt_dp.sv =====
`include "multicast_group_table_macros.svh"
module mgt_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mgt_pkg::t_req  i_req,
    input  mgt_pkg::t_cmd  i_cmd,
    output mgt_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mgt_pkg::t_rsp  o_rsp
);
    localparam int unsigned GW = mgt_pkg::GidW;
    localparam int unsigned MW = mgt_pkg::MaskW;
    localparam int unsigned CW = $clog2(mgt_pkg::NumNodes + 1);
    localparam logic [GW-1:0] MaxId = GW'(mgt_pkg::MaxGroup);
    localparam logic [MW-1:0] FieldMask = MW'({mgt_pkg::NumNodes{1'b1}});

    logic [MW-1:0] r_mem [0:mgt_pkg::MaxGroup];
    logic [MW-1:0] r_rd;
    logic [mgt_pkg::MaxGroup:0] r_valid, r_lock;

    logic [2:0]    r_mode;
    logic [MW-1:0] r_list;
    logic [6:0]    r_node;
    logic [GW-1:0] r_gid;
    logic [GW-1:0] r_id, r_rd_id, r_best, r_ptr, r_start;
    logic [CW-1:0] r_best_cnt;
    // pending result and write
    logic [1:0]    r_status;
    logic [GW-1:0] r_res;
    logic          r_rsp_rd, r_reuse;
    logic          r_wr_en, r_wr_lock;
    logic [GW-1:0] r_wr_id;
    logic [MW-1:0] r_wr_data;
    logic          r_out_valid;
    mgt_pkg::t_rsp r_rsp;
    // marks the cycle after a reuse step
    logic          r_reu_chk;

    logic          sub_ok, sub_eq;
    logic [CW-1:0] cnt;
    logic [GW-1:0] ptr_nx;
    logic          gid_bad;
    logic [MW-1:0] bit_mask;
    logic          reu_free;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < mgt_pkg::NumNodes; i++) begin
            cnt = cnt + CW'(r_rd[i]);
        end
    end

    assign sub_ok   = r_valid[r_rd_id] && !r_lock[r_rd_id] && ((r_rd & ~r_list) == '0);
    assign sub_eq   = sub_ok && (r_rd == r_list);
    assign ptr_nx   = (r_ptr >= MaxId) ? GW'(1) : r_ptr + GW'(1);
    assign gid_bad  = (r_gid == '0) || (r_gid > MaxId);
    assign bit_mask = MW'(1) << (r_node - 7'd1);
    assign reu_free = !(r_valid[r_ptr] && r_lock[r_ptr]);

    assign o_stat.mode      = mgt_pkg::t_mode'(r_mode);
    assign o_stat.list_zero = (r_list == '0);
    assign o_stat.sub_last  = (r_rd_id == MaxId);
    assign o_stat.sub_hit   = sub_eq;
    assign o_stat.best_zero = (r_best == '0) && !(sub_ok && cnt > r_best_cnt);
    // from pointer zero the scan ends at the last id
    assign o_stat.reu_done  = (r_ptr == r_start)
                              || ((r_start == '0) && (r_ptr == MaxId) && !reu_free);
    assign o_stat.reu_free  = reu_free;
    assign o_stat.out_busy  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req.mode;
            r_list <= i_req.node_mask & FieldMask;
            r_node <= i_req.node_id;
            r_gid  <= i_req.grp_sel;
        end
        if (i_cmd.sub_start) begin
            r_id <= GW'(1);
            r_best <= '0;
            r_best_cnt <= '0;
        end
        // memory read port, address from scan or addressed group
        if (i_cmd.one_rd) begin
            r_rd <= r_mem[r_gid];
        end else if (r_mode == mgt_pkg::MODE_ASSIGN) begin
            r_rd    <= r_mem[r_id];
            r_rd_id <= r_id;
        end
        if (i_cmd.sub_next) begin
            r_id <= r_id + GW'(1);
            if (sub_ok && cnt > r_best_cnt) begin
                r_best <= r_rd_id;
                r_best_cnt <= cnt;
            end
        end
        if (i_cmd.wr && r_wr_en) begin
            r_mem[r_wr_id] <= r_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_lock <= '0;
            r_ptr <= '0;
            r_out_valid <= 1'b0;
            r_wr_en <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_wr_en  <= 1'b0;
                r_status <= mgt_pkg::STAT_FAIL;
                r_res    <= '0;
                r_rsp_rd <= 1'b0;
                r_reuse  <= 1'b0;
                if (i_req.mode >= mgt_pkg::MODE_ADD && i_req.mode <= mgt_pkg::MODE_READ)
                    r_res <= i_req.grp_sel;
            end
            if (i_cmd.sub_next && (sub_eq || o_stat.sub_last)) begin
                if (sub_eq || !o_stat.best_zero) begin
                    r_wr_en   <= 1'b1;
                    r_wr_id   <= sub_eq ? r_rd_id :
                                 ((sub_ok && cnt > r_best_cnt) ? r_rd_id : r_best);
                    r_wr_data <= r_list;
                    r_wr_lock <= 1'b0;
                    r_status  <= mgt_pkg::STAT_OK;
                    r_res     <= sub_eq ? r_rd_id :
                                 ((sub_ok && cnt > r_best_cnt) ? r_rd_id : r_best);
                end
            end
            if (i_cmd.reu_start) r_start <= r_ptr;
            if (i_cmd.reu_step) r_ptr <= ptr_nx;
            if (i_cmd.one_do) begin
                if (gid_bad || r_mode > mgt_pkg::MODE_READ) begin
                    r_status <= mgt_pkg::STAT_FAIL;
                end else if (r_mode == mgt_pkg::MODE_ADD) begin
                    if (r_node == '0 || r_node > 7'(mgt_pkg::NumNodes)
                        || (r_valid[r_gid] && r_lock[r_gid])) begin
                        r_status <= mgt_pkg::STAT_FAIL;
                    end else begin
                        r_status  <= mgt_pkg::STAT_OK;
                        r_wr_en   <= 1'b1;
                        r_wr_id   <= r_gid;
                        r_wr_data <= r_valid[r_gid] ? (r_rd | bit_mask) : bit_mask;
                        r_wr_lock <= 1'b0;
                    end
                end else if (!r_valid[r_gid]) begin
                    r_status <= mgt_pkg::STAT_NF;
                end else begin
                    r_status <= mgt_pkg::STAT_OK;
                    if (r_mode == mgt_pkg::MODE_LOCK || r_mode == mgt_pkg::MODE_UNLOCK) begin
                        r_lock[r_gid] <= (r_mode == mgt_pkg::MODE_LOCK);
                    end else begin
                        r_rsp_rd <= 1'b1;
                    end
                end
            end
            if (i_cmd.wr && r_wr_en) begin
                r_valid[r_wr_id] <= 1'b1;
                r_lock[r_wr_id]  <= r_wr_lock;
            end
            if (i_cmd.out_set) begin
                r_out_valid <= 1'b1;
                r_rsp.status <= r_status;
                r_rsp.result_group <= r_res;
                r_rsp.member_mask <= r_rsp_rd ? r_rd : '0;
                r_rsp.group_locked <= r_rsp_rd ? r_lock[r_gid] : 1'b0;
                r_rsp.reuse_notice <= r_reuse;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // reuse probe outcome, evaluated after each step
            if (r_reu_chk) begin
                if (!o_stat.reu_done && o_stat.reu_free) begin
                    r_wr_en   <= 1'b1;
                    r_wr_id   <= r_ptr;
                    r_wr_data <= r_list;
                    r_wr_lock <= 1'b0;
                    r_status  <= mgt_pkg::STAT_OK;
                    r_res     <= r_ptr;
                    r_reuse   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reu_chk <= 1'b0;
        else r_reu_chk <= i_cmd.reu_step;
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp = r_rsp;

    `MGT_ASSERT(a_wr_excl, !(i_cmd.wr && i_cmd.sub_next), "write during scan")
    `MGT_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> o_out_valid, "result dropped")
    `MGT_ASSERT(a_ptr_range, r_ptr <= MaxId, "reuse pointer out of range")
    `MGT_ASSERT(a_reuse_ok, (i_cmd.out_set && r_reuse) |-> (r_status == mgt_pkg::STAT_OK), "reuse without ok")
endmodule

// ===== rtl/core/multicast_group_table.sv =====
// Multicast group table for ids 1..255 with 64-node masks. One request is taken
// at a time and gives one result. Lock, unlock, read and add-node read only the
// addressed entry. Assign scans the entries in id order through the single mask
// memory read port and stops early at an identical group; then, if no subset
// matched, it steps the reuse pointer. No clearing pass is needed after reset.
module multicast_group_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mgt_req_if.sink    req,
    mgt_rsp_if.source  rsp
);
    mgt_pkg::t_cmd  cmd;
    mgt_pkg::t_stat stat;

    mgt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req.valid),
        .o_in_ready (req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mgt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req.payload),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (rsp.valid),
        .i_out_ready (rsp.ready),
        .o_rsp       (rsp.payload)
    );
endmodule

// ===== sim/mgt_checker.sv =====
`timescale 1ns / 100ps

module mgt_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mgt_req_if    req,
    mgt_rsp_if    rsp,
    output int    o_fail_count,
    output int    o_pending
);
    logic [mgt_pkg::MaskW-1:0] group_mask [0:mgt_pkg::MaxGroup];
    bit                        group_ok   [0:mgt_pkg::MaxGroup];
    bit                        group_held [0:mgt_pkg::MaxGroup];
    logic [mgt_pkg::GidW-1:0]  reuse_ptr;
    mgt_pkg::t_rsp             expected_rsp [$];
    int                        n_fail;

    assign o_fail_count = n_fail;
    assign o_pending    = expected_rsp.size();

    function automatic bit held(int id);
        return group_ok[id] && group_held[id];
    endfunction

    function automatic mgt_pkg::t_rsp predict_request(mgt_pkg::t_req r);
        mgt_pkg::t_rsp o;
        int    best;
        int    best_cnt;
        int    cnt;
        int    gid;
        int    start;
        bit    found;
        logic [mgt_pkg::MaskW-1:0] bitv;
        o = '0;
        o.status = mgt_pkg::STAT_FAIL;
        gid = r.grp_sel;
        if (r.mode == mgt_pkg::MODE_ASSIGN) begin
            if (r.node_mask != '0) begin
                best = 0;
                best_cnt = 0;
                found = 0;
                for (int id = 1; id <= mgt_pkg::MaxGroup && !found; id++) begin
                    if (!group_ok[id] || group_held[id]) continue;
                    if ((group_mask[id] & ~r.node_mask) != '0) continue;
                    if (group_mask[id] == r.node_mask) begin
                        best = id;
                        found = 1;
                    end else begin
                        cnt = $countones(group_mask[id]);
                        if (cnt > best_cnt) begin
                            best_cnt = cnt;
                            best = id;
                        end
                    end
                end
                if (best == 0) begin
                    start = reuse_ptr;
                    for (int i = 0; i < mgt_pkg::MaxGroup; i++) begin
                        reuse_ptr = (reuse_ptr >= mgt_pkg::MaxGroup) ? mgt_pkg::GidW'(1)
                                                                     : reuse_ptr + 1'b1;
                        if (reuse_ptr == start) break;
                        if (!held(reuse_ptr)) begin
                            best = reuse_ptr;
                            o.reuse_notice = 1'b1;
                            break;
                        end
                    end
                end
                if (best != 0) begin
                    group_mask[best] = r.node_mask;
                    group_ok[best] = 1;
                    group_held[best] = 0;
                    o.status = mgt_pkg::STAT_OK;
                    o.result_group = mgt_pkg::GidW'(best);
                end
            end
        end else if (r.mode <= mgt_pkg::MODE_READ) begin
            o.result_group = r.grp_sel;
            if (gid == 0 || gid > mgt_pkg::MaxGroup) begin
                o.status = mgt_pkg::STAT_FAIL;
            end else if (r.mode == mgt_pkg::MODE_ADD) begin
                if (r.node_id == 0 || r.node_id > mgt_pkg::NumNodes || held(gid)) begin
                    o.status = mgt_pkg::STAT_FAIL;
                end else begin
                    bitv = '0;
                    bitv[r.node_id - 1] = 1'b1;
                    if (group_ok[gid]) begin
                        group_mask[gid] |= bitv;
                    end else begin
                        group_mask[gid] = bitv;
                        group_ok[gid] = 1;
                        group_held[gid] = 0;
                    end
                    o.status = mgt_pkg::STAT_OK;
                end
            end else if (!group_ok[gid]) begin
                o.status = mgt_pkg::STAT_NF;
            end else begin
                o.status = mgt_pkg::STAT_OK;
                if (r.mode == mgt_pkg::MODE_LOCK) begin
                    group_held[gid] = 1;
                end else if (r.mode == mgt_pkg::MODE_UNLOCK) begin
                    group_held[gid] = 0;
                end else begin
                    o.member_mask = group_mask[gid];
                    o.group_locked = group_held[gid];
                end
            end
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        mgt_pkg::t_rsp e;
        if (!i_rst_n) begin
            for (int i = 0; i <= mgt_pkg::MaxGroup; i++) begin
                group_mask[i] = '0;
                group_ok[i] = 0;
                group_held[i] = 0;
            end
            reuse_ptr = '0;
            expected_rsp.delete();
            n_fail = 0;
        end else begin
            if (req.valid && req.ready)
                expected_rsp.push_back(predict_request(req.payload));
            if (rsp.valid && rsp.ready) begin
                if (expected_rsp.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result %p", rsp.payload);
                end else begin
                    e = expected_rsp.pop_front();
                    if (rsp.payload.status !== e.status
                            || rsp.payload.result_group !== e.result_group
                            || rsp.payload.member_mask !== e.member_mask
                            || rsp.payload.group_locked !== e.group_locked
                            || rsp.payload.reuse_notice !== e.reuse_notice) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch: expected %p actual %p", e, rsp.payload);
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count;
    int   pending;
    int   hold_off = 0;
    bit   long_stall = 0;

    mgt_req_if req ();
    mgt_rsp_if rsp ();

    multicast_group_table i_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp));
    mgt_checker i_chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
                       .o_fail_count(fail_count), .o_pending(pending));

    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 0;
        end else if (long_stall) begin
            rsp.ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp.ready <= 0;
        end else begin
            hold_off <= (($urandom_range(0, 3) == 0) ? gap_len() : 0);
            rsp.ready <= 1;
        end
    end

    function automatic logic [63:0] rand_mask();
        logic [63:0] m;
        int k;
        k = $urandom_range(0, 9);
        m = {$urandom, $urandom};
        if (k < 5) begin
            m = '0;
            for (int i = 0; i < $urandom_range(1, 4); i++) m[$urandom_range(0, 63)] = 1;
        end else if (k < 7) begin
            m = m & {$urandom, $urandom};
        end
        return m;
    endfunction

    task automatic send(logic [2:0] mode, logic [63:0] mask, logic [6:0] node,
                        logic [7:0] gid);
        mgt_pkg::t_req r;
        r.mode = mode;
        r.node_mask = mask;
        r.node_id = node;
        r.grp_sel = gid;
        req.payload <= r;
        req.valid <= 1;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic idle_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            req.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int k;
        logic [7:0] g;
        k = $urandom_range(0, 99);
        g = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
        if ($urandom_range(0, 49) == 0) g = 0;
        if (k < 30)      send(mgt_pkg::MODE_ASSIGN, rand_mask(), 7'($urandom), g);
        else if (k < 50) send(mgt_pkg::MODE_ADD, 64'($urandom),
                              ($urandom_range(0, 15) == 0) ? 7'($urandom)
                                                          : 7'($urandom_range(1, 64)), g);
        else if (k < 65) send(mgt_pkg::MODE_LOCK, 64'($urandom), 7'($urandom), g);
        else if (k < 78) send(mgt_pkg::MODE_UNLOCK, 64'($urandom), 7'($urandom), g);
        else if (k < 96) send(mgt_pkg::MODE_READ, 64'($urandom), 7'($urandom), g);
        else             send(3'($urandom_range(5, 7)), {$urandom, $urandom},
                              7'($urandom), 8'($urandom));
    endtask

    initial begin
        req.valid <= 0;
        req.payload <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed corner cases
        send(mgt_pkg::MODE_ASSIGN, 64'h1, 7'd0, 8'd0);
        send(mgt_pkg::MODE_ASSIGN, 64'h0, 7'd0, 8'd0);
        send(mgt_pkg::MODE_READ, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_LOCK, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd1, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd64, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd65, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd127, 8'd255);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd3, 8'd0);
        send(mgt_pkg::MODE_READ, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_ASSIGN, 64'h8000_0000_0000_0001, 7'd0, 8'd0);
        send(mgt_pkg::MODE_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 8'd0);
        send(mgt_pkg::MODE_LOCK, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_ADD, 64'h0, 7'd2, 8'd5);
        send(mgt_pkg::MODE_ASSIGN, 64'h8000_0000_0000_0001, 7'd0, 8'd0);
        send(mgt_pkg::MODE_ASSIGN, 64'h0000_0000_0000_0003, 7'd0, 8'd0);
        send(mgt_pkg::MODE_UNLOCK, 64'h0, 7'd0, 8'd5);
        send(mgt_pkg::MODE_UNLOCK, 64'h0, 7'd0, 8'd200);
        send(mgt_pkg::MODE_READ, 64'h0, 7'd0, 8'd255);
        send(mgt_pkg::MODE_READ, 64'h0, 7'd0, 8'd0);
        send(3'd5, 64'h0, 7'd0, 8'd1);
        send(3'd7, '1, '1, '1);
        drain();
        // long receiver hold-off while items keep coming
        long_stall <= 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                long_stall <= 0;
            end
            for (int i = 0; i < 10; i++) random_item();
        join
        for (int i = 0; i < 1130; i++) begin
            if (i == 500) drain();
            random_item();
            idle_gap();
        end
        drain();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end
endmodule
